// ----- sv/slpg_pkg.sv -----
// ---------------------------------------------------------------------------
// slpg_pkg: status LED pattern generator shared definitions
// Register indexes, reset values, phase codes and the state record.
// ---------------------------------------------------------------------------
`default_nettype none

package slpg_pkg;

  localparam int unsigned CfgWidth   = 16;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned ClockWidth = 32;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_SHORT_INTERVAL = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_HB_PAUSE       = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_BLINK_PAUSE    = 2'd2;

  localparam logic [CfgWidth-1:0] SHORT_INTERVAL_RST = 16'd200;
  localparam logic [CfgWidth-1:0] HB_PAUSE_RST       = 16'd700;
  localparam logic [CfgWidth-1:0] BLINK_PAUSE_RST    = 16'd1000;

  // motor status codes
  localparam logic [2:0] MS_UNCALIBRATED = 3'd0;
  localparam logic [2:0] MS_RUNNING      = 3'd1;
  localparam logic [2:0] MS_FINISHED     = 3'd2;
  localparam logic [2:0] MS_STOPPED      = 3'd3;
  localparam logic [2:0] MS_OVERLOAD     = 3'd4;
  localparam logic [2:0] MS_STALL        = 3'd5;

  // heartbeat phases
  localparam logic [1:0] HB_ON1  = 2'd0;
  localparam logic [1:0] HB_OFF1 = 2'd1;
  localparam logic [1:0] HB_ON2  = 2'd2;
  localparam logic [1:0] HB_REST = 2'd3;

  // blink phases
  localparam logic [1:0] BL_ON    = 2'd0;
  localparam logic [1:0] BL_OFF   = 2'd1;
  localparam logic [1:0] BL_PAUSE = 2'd2;

  localparam logic [2:0] BLINKS_MAX = 3'd7;

  typedef struct packed {
    logic [CfgWidth-1:0] short_interval_ms;
    logic [CfgWidth-1:0] heartbeat_pause_ms;
    logic [CfgWidth-1:0] blink_pause_ms;
  } cfg_t;

  typedef struct packed {
    logic [ClockWidth-1:0] clock_ms;
    logic [ClockWidth-1:0] heartbeat_mark;
    logic [ClockWidth-1:0] blink_mark;
    logic [1:0]            heartbeat_phase;
    logic [1:0]            blink_phase;
    logic [2:0]            blinks_done;
    logic [1:0]            target_blinks;
    logic                  led_enable;
    logic                  heartbeat_on;
    logic                  status_level;
    logic                  blink_level;
  } state_t;

endpackage

`default_nettype wire

// ----- sv/slpg_in_if.sv -----
// ---------------------------------------------------------------------------
// slpg_in_if: tick channel
// Valid/ready channel carrying elapsed time and motor status.
// ---------------------------------------------------------------------------
`default_nettype none

interface slpg_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] elapsed_ms;
  logic [2:0]  motor_state;

  modport source (output valid, output elapsed_ms, output motor_state, input ready);
  modport sink   (input valid, input elapsed_ms, input motor_state, output ready);
endinterface

`default_nettype wire

// ----- sv/slpg_out_if.sv -----
// ---------------------------------------------------------------------------
// slpg_out_if: LED level channel
// Valid/ready channel carrying both LED levels.
// ---------------------------------------------------------------------------
`default_nettype none

interface slpg_out_if;
  logic valid;
  logic ready;
  logic status_led;
  logic blink_led;

  modport source (output valid, output status_led, output blink_led, input ready);
  modport sink   (input valid, input status_led, input blink_led, output ready);
endinterface

`default_nettype wire

// ----- sv/slpg_core.sv -----
// ---------------------------------------------------------------------------
// slpg_core: per-tick update
// Advances the clock, decodes the status and steps both LED machines.
// ---------------------------------------------------------------------------
`default_nettype none

module slpg_core
  import slpg_pkg::*;
(
  input  state_t      cur,
  input  cfg_t        cfg,
  input  logic [15:0] elapsed_ms,
  input  logic [2:0]  motor_state,
  output state_t      nxt
);

  logic [ClockWidth-1:0] clk_now;
  logic [ClockWidth-1:0] hb_diff;
  logic [ClockWidth-1:0] bl_diff;
  logic [CfgWidth-1:0]   hb_limit;
  logic [CfgWidth-1:0]   bl_limit;
  logic                  hb_passed;
  logic                  bl_passed;
  logic [2:0]            done_inc;
  logic                  led_en;
  logic                  hb_en;
  logic [1:0]            target;

  assign clk_now = cur.clock_ms + {{(ClockWidth-16){1'b0}}, elapsed_ms};
  assign hb_diff = clk_now - cur.heartbeat_mark;
  assign bl_diff = clk_now - cur.blink_mark;

  assign hb_limit = (cur.heartbeat_phase == HB_REST) ? cfg.heartbeat_pause_ms
                                                     : cfg.short_interval_ms;
  assign bl_limit = (cur.blink_phase == BL_PAUSE) ? cfg.blink_pause_ms
                                                  : cfg.short_interval_ms;

  // strict compare on the wrapped difference
  assign hb_passed = hb_diff > {{(ClockWidth-CfgWidth){1'b0}}, hb_limit};
  assign bl_passed = bl_diff > {{(ClockWidth-CfgWidth){1'b0}}, bl_limit};

  assign done_inc = (cur.blinks_done < BLINKS_MAX) ? cur.blinks_done + 3'd1
                                                   : cur.blinks_done;

  always_comb begin
    led_en = cur.led_enable;
    hb_en  = cur.heartbeat_on;
    target = cur.target_blinks;
    unique case (motor_state)
      MS_UNCALIBRATED: begin led_en = 1'b0; hb_en = 1'b0; target = 2'd1; end
      MS_RUNNING:      begin led_en = 1'b1; hb_en = 1'b1; target = 2'd0; end
      MS_FINISHED:     begin led_en = 1'b1; hb_en = 1'b0; target = 2'd0; end
      MS_STOPPED:      begin led_en = 1'b0; hb_en = 1'b0; target = 2'd0; end
      MS_OVERLOAD:     begin led_en = 1'b1; hb_en = 1'b0; target = 2'd3; end
      MS_STALL:        begin led_en = 1'b0; hb_en = 1'b0; target = 2'd2; end
      default: ;       // keep settings
    endcase
  end

  always_comb begin
    nxt               = cur;
    nxt.clock_ms      = clk_now;
    nxt.led_enable    = led_en;
    nxt.heartbeat_on  = hb_en;
    nxt.target_blinks = target;

    // status LED
    if (led_en) begin
      if (hb_en) begin
        if (hb_passed) begin
          nxt.status_level    = (cur.heartbeat_phase == HB_OFF1) ||
                                (cur.heartbeat_phase == HB_REST);
          nxt.heartbeat_mark  = clk_now;
          nxt.heartbeat_phase = cur.heartbeat_phase + 2'd1;
        end
      end else begin
        nxt.status_level    = 1'b1;
        nxt.heartbeat_phase = HB_ON1;
      end
    end else begin
      nxt.status_level = 1'b0;
    end

    // blink LED
    unique case (cur.blink_phase)
      BL_ON: begin
        if (bl_passed) begin
          nxt.blink_level = 1'b0;
          nxt.blink_mark  = clk_now;
          nxt.blink_phase = BL_OFF;
        end
      end
      BL_OFF: begin
        if (bl_passed) begin
          nxt.blinks_done = done_inc;
          nxt.blink_mark  = clk_now;
          if ({1'b0, target} > done_inc) begin
            nxt.blink_level = 1'b1;
            nxt.blink_phase = BL_ON;
          end else begin
            nxt.blink_level = 1'b0;
            nxt.blink_phase = BL_PAUSE;
          end
        end
      end
      BL_PAUSE: begin
        if (bl_passed) begin
          nxt.blinks_done = 3'd0;
          nxt.blink_level = (target != 2'd0);
          nxt.blink_mark  = clk_now;
          nxt.blink_phase = BL_ON;
        end
      end
      default: ;       // unused code holds
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/status_led_pattern_generator.sv -----
// ---------------------------------------------------------------------------
// status_led_pattern_generator: status and blink LED driver
// Turns timed motor status ticks into two LED levels.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries one tick per transfer: elapsed milliseconds and the motor
//   status code. out_ch returns one transfer per tick with both LED levels.
//   cfg_we/cfg_index/cfg_wdata write the short interval, heartbeat pause and
//   blink pause; write them only while no tick is in flight.
//   An input transfer loads the tick register; the update logic works on it
//   there, and the result register loads when the result side can advance.
//   Throughput is one tick per cycle while the receiver does not stall; the
//   limit is the loop through the state register, the 32-bit clock add,
//   the mark subtracts and the interval compares.
//   When the receiver stalls, the result register holds and the tick
//   register still fills, then in_ch.ready drops until the result moves.
//   Synchronous reset clears clock, marks, phases and settings, loads the
//   default intervals and empties both registers.
// ---------------------------------------------------------------------------
`default_nettype none

module status_led_pattern_generator
  import slpg_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  slpg_in_if.sink                  in_ch,
  slpg_out_if.source               out_ch,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgWidth-1:0] cfg_wdata
);

  cfg_t        cfg_r;
  state_t      state_r;
  state_t      state_nxt;
  logic        tick_vld_r;
  logic [15:0] tick_elapsed_r;
  logic [2:0]  tick_state_r;
  logic        out_vld_r;
  logic        status_led_r;
  logic        blink_led_r;
  logic        advance;

  assign advance      = !out_vld_r || out_ch.ready;
  assign in_ch.ready  = !tick_vld_r || advance;
  assign out_ch.valid = out_vld_r;
  assign out_ch.status_led = status_led_r;
  assign out_ch.blink_led  = blink_led_r;

  slpg_core u_core (
    .cur         (state_r),
    .cfg         (cfg_r),
    .elapsed_ms  (tick_elapsed_r),
    .motor_state (tick_state_r),
    .nxt         (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_interval_ms  <= SHORT_INTERVAL_RST;
      cfg_r.heartbeat_pause_ms <= HB_PAUSE_RST;
      cfg_r.blink_pause_ms     <= BLINK_PAUSE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHORT_INTERVAL: cfg_r.short_interval_ms  <= cfg_wdata;
        REG_HB_PAUSE:       cfg_r.heartbeat_pause_ms <= cfg_wdata;
        REG_BLINK_PAUSE:    cfg_r.blink_pause_ms     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // tick register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      tick_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      tick_elapsed_r <= in_ch.elapsed_ms;
      tick_state_r   <= in_ch.motor_state;
    end
  end

  // state and result register, updated when a tick moves forward
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= '0;
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= tick_vld_r;
      if (tick_vld_r) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && tick_vld_r) begin
      status_led_r <= state_nxt.status_level;
      blink_led_r  <= state_nxt.blink_level;
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_vld_r || out_ch.ready) |-> in_ch.ready)
    else $error("tick channel blocked while result register free");

  a_disabled_dark: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.led_enable |-> !state_r.status_level)
    else $error("status LED lit while disabled");

  a_steady_on: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.led_enable && !state_r.heartbeat_on) |->
      (state_r.status_level && state_r.heartbeat_phase == HB_ON1))
    else $error("steady mode not lit or heartbeat phase not reset");

  a_blink_phase_used: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.blink_phase != 2'd3)
    else $error("blink machine in unused phase");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: status LED pattern generator testbench
// Drives timed motor status ticks into the generator, predicts both LED
// levels for every accepted tick and compares each returned transfer in
// order. Directed ticks cover heartbeat and blink phase edges, then random
// traffic runs under several interval settings and idle mixes, including a
// long receiver stall.
// ---------------------------------------------------------------------------

module tb_top
  import slpg_pkg::*;
();

  // status codes that leave the decoded settings untouched
  localparam logic [2:0] MS_KEEP     = 3'd6;
  localparam logic [2:0] MS_KEEP_ALT = 3'd7;
  // register index with no register behind it
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic status_led;
    logic blink_led;
  } led_levels_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgWidth-1:0] cfg_wdata;

  slpg_in_if  in_if();
  slpg_out_if out_if();

  status_led_pattern_generator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predicted block state
  logic [15:0] short_ms, hb_pause_ms, bl_pause_ms;
  logic [31:0] ms_clock, hb_mark, bl_mark;
  logic [1:0]  hb_phase, bl_phase;
  logic [2:0]  blink_count;
  logic [1:0]  blink_target;
  logic        status_en, hb_en, status_lvl, blink_lvl;

  led_levels_t expected_leds[$];
  led_levels_t oldest_leds;
  int          ticks_taken = 0;
  int          fault_count = 0;
  int          src_idle_pct = 0;
  int          sink_idle_pct = 0;
  int          stall_left = 0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void reset_model();
    short_ms     = SHORT_INTERVAL_RST;
    hb_pause_ms  = HB_PAUSE_RST;
    bl_pause_ms  = BLINK_PAUSE_RST;
    ms_clock     = '0;
    hb_mark      = '0;
    bl_mark      = '0;
    hb_phase     = HB_ON1;
    bl_phase     = BL_ON;
    blink_count  = '0;
    blink_target = '0;
    status_en    = 1'b0;
    hb_en        = 1'b0;
    status_lvl   = 1'b0;
    blink_lvl    = 1'b0;
  endfunction

  // strict test on the wrapping difference
  function automatic logic interval_over(input logic [31:0] mark, input logic [15:0] span);
    return (ms_clock - mark) > {16'd0, span};
  endfunction

  function automatic led_levels_t advance_leds(input logic [15:0] elapsed,
                                               input logic [2:0] code);
    led_levels_t levels;
    logic [15:0] span;
    ms_clock = ms_clock + {16'd0, elapsed};
    case (code)
      MS_UNCALIBRATED: begin status_en = 1'b0; hb_en = 1'b0; blink_target = 2'd1; end
      MS_RUNNING:      begin status_en = 1'b1; hb_en = 1'b1; blink_target = 2'd0; end
      MS_FINISHED:     begin status_en = 1'b1; hb_en = 1'b0; blink_target = 2'd0; end
      MS_STOPPED:      begin status_en = 1'b0; hb_en = 1'b0; blink_target = 2'd0; end
      MS_OVERLOAD:     begin status_en = 1'b1; hb_en = 1'b0; blink_target = 2'd3; end
      MS_STALL:        begin status_en = 1'b0; hb_en = 1'b0; blink_target = 2'd2; end
      default: ;
    endcase

    if (status_en && hb_en) begin
      span = (hb_phase == HB_REST) ? hb_pause_ms : short_ms;
      if (interval_over(hb_mark, span)) begin
        // the two on phases end by going dark, the off phases by lighting
        status_lvl = (hb_phase == HB_OFF1) || (hb_phase == HB_REST);
        hb_mark    = ms_clock;
        hb_phase   = hb_phase + 2'd1;
      end
    end else if (status_en) begin
      status_lvl = 1'b1;
      hb_phase   = HB_ON1;
    end else begin
      status_lvl = 1'b0;
    end

    case (bl_phase)
      BL_ON: begin
        if (interval_over(bl_mark, short_ms)) begin
          blink_lvl = 1'b0;
          bl_mark   = ms_clock;
          bl_phase  = BL_OFF;
        end
      end
      BL_OFF: begin
        if (interval_over(bl_mark, short_ms)) begin
          if (blink_count != BLINKS_MAX) blink_count = blink_count + 3'd1;
          if ({1'b0, blink_target} > blink_count) begin
            blink_lvl = 1'b1;
            bl_phase  = BL_ON;
          end else begin
            blink_lvl = 1'b0;
            bl_phase  = BL_PAUSE;
          end
          bl_mark = ms_clock;
        end
      end
      BL_PAUSE: begin
        if (interval_over(bl_mark, bl_pause_ms)) begin
          blink_count = '0;
          blink_lvl   = (blink_target != 2'd0);
          bl_mark     = ms_clock;
          bl_phase    = BL_ON;
        end
      end
      default: ;
    endcase

    levels.status_led = status_lvl;
    levels.blink_led  = blink_lvl;
    return levels;
  endfunction

  // tick transfers are predicted before results are checked at the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        expected_leds.push_back(advance_leds(in_if.elapsed_ms, in_if.motor_state));
        ticks_taken++;
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_leds.size() == 0) begin
          fault_count++;
          $display("%0t: unexpected LED transfer status_led=%b blink_led=%b",
                   $time, out_if.status_led, out_if.blink_led);
        end else begin
          oldest_leds = expected_leds.pop_front();
          if (out_if.status_led !== oldest_leds.status_led) begin
            fault_count++;
            $display("%0t: status_led expected %b actual %b",
                     $time, oldest_leds.status_led, out_if.status_led);
          end
          if (out_if.blink_led !== oldest_leds.blink_led) begin
            fault_count++;
            $display("%0t: blink_led expected %b actual %b",
                     $time, oldest_leds.blink_led, out_if.blink_led);
          end
        end
      end
    end
  end

  // receiver: random idling, or a counted hold-off when one is requested
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // valid stays high on return so back-to-back ticks need no reassignment
  task automatic send_tick(input logic [15:0] elapsed, input logic [2:0] code);
    int taken_before;
    if ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.elapsed_ms  <= elapsed;
    in_if.motor_state <= code;
    taken_before = ticks_taken;
    do @(negedge clk); while (ticks_taken == taken_before);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (expected_leds.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_idling(input int src_pct, input int sink_pct);
    @(posedge clk);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    @(negedge clk);
  endtask

  // only called while idle; the unused index gets a random write as well
  task automatic apply_settings(input logic [15:0] short_val, input logic [15:0] hb_val,
                                input logic [15:0] bl_val);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SHORT_INTERVAL;
    cfg_wdata <= short_val;
    @(negedge clk);
    cfg_index <= REG_HB_PAUSE;
    cfg_wdata <= hb_val;
    @(negedge clk);
    cfg_index <= REG_BLINK_PAUSE;
    cfg_wdata <= bl_val;
    @(negedge clk);
    cfg_index <= REG_UNUSED;
    cfg_wdata <= 16'($urandom_range(0, 65535));
    @(negedge clk);
    cfg_we <= 1'b0;
    short_ms    = short_val;
    hb_pause_ms = hb_val;
    bl_pause_ms = bl_val;
    @(negedge clk);
  endtask

  task automatic test_heartbeat_steps();
    send_tick(16'd0, MS_RUNNING);
    send_tick(16'd200, MS_KEEP);      // equal to the interval, no step yet
    send_tick(16'd1, MS_KEEP);
    send_tick(16'd201, MS_KEEP_ALT);
    send_tick(16'd201, MS_KEEP);
    send_tick(16'd700, MS_KEEP);
    send_tick(16'd1, MS_KEEP);
    send_tick(16'hFFFF, MS_STOPPED);  // dark, heartbeat phase held
    send_tick(16'd0, MS_RUNNING);
    send_tick(16'd5, MS_FINISHED);    // steady on, heartbeat restarts
    send_tick(16'd300, MS_RUNNING);
  endtask

  task automatic test_blink_bursts();
    send_tick(16'd1001, MS_OVERLOAD);
    send_tick(16'd201, MS_KEEP);
    send_tick(16'd201, MS_KEEP);
    send_tick(16'd201, MS_KEEP_ALT);
    send_tick(16'd201, MS_UNCALIBRATED); // target lowered mid burst
    send_tick(16'd201, MS_KEEP);
    send_tick(16'd1001, MS_STALL);
    send_tick(16'd201, MS_KEEP);
    send_tick(16'd201, MS_KEEP);
    send_tick(16'd201, MS_STOPPED);      // zero target, machine still runs
    send_tick(16'hFFFF, MS_KEEP_ALT);
  endtask

  task automatic test_config_extremes();
    drain();
    apply_settings(16'd0, 16'd0, 16'd0);
    send_tick(16'd0, MS_RUNNING);
    send_tick(16'd1, MS_OVERLOAD);
    send_tick(16'd0, MS_KEEP);
    send_tick(16'd1, MS_KEEP);
    send_tick(16'd1, MS_KEEP);
    drain();
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_tick(16'hFFFF, MS_RUNNING);
    send_tick(16'd1, MS_KEEP);
    send_tick(16'hFFFF, MS_STALL);
    send_tick(16'd1, MS_KEEP);
    drain();
  endtask

  // runs of one status code with keep codes and stray codes mixed in
  task automatic test_random_traffic(input int count, input int span);
    logic [2:0]  run_code;
    logic [2:0]  code;
    logic [15:0] elapsed;
    int          run_left;
    int          roll;
    run_left = 0;
    run_code = MS_RUNNING;
    for (int i = 0; i < count; i++) begin
      if (run_left == 0) begin
        run_code = 3'($urandom_range(0, 5));
        run_left = $urandom_range(3, 40);
      end
      run_left--;
      roll = $urandom_range(99);
      if (roll < 10)      code = 3'($urandom_range(0, 7));
      else if (roll < 35) code = $urandom_range(0, 1) ? MS_KEEP : MS_KEEP_ALT;
      else                code = run_code;
      roll = $urandom_range(99);
      if (roll < 4) begin
        elapsed = 16'($urandom_range(0, 65535));
      end else if (roll < 8) begin
        elapsed = short_ms;
        if ($urandom_range(0, 1) && short_ms != 16'hFFFF) elapsed = short_ms + 16'd1;
      end else begin
        elapsed = 16'($urandom_range(0, span));
      end
      send_tick(elapsed, code);
    end
  endtask

  task automatic test_backpressure();
    drain();
    @(posedge clk);
    stall_left = 80;
    @(negedge clk);
    test_random_traffic(20, 250);
    drain();          // sender waits for every result before going on
    test_random_traffic(15, 250);
    drain();
  endtask

  initial begin
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.elapsed_ms  = '0;
    in_if.motor_state = MS_UNCALIBRATED;
    cfg_we            = 1'b0;
    cfg_index         = REG_SHORT_INTERVAL;
    cfg_wdata         = '0;
    reset_model();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_idling(28, 56);
    test_heartbeat_steps();
    test_blink_bursts();
    test_random_traffic(200, 400);
    test_config_extremes();

    set_idling(56, 28);
    apply_settings(16'd40, 16'd150, 16'd250);
    test_random_traffic(200, 120);
    test_backpressure();

    set_idling(0, 0);
    apply_settings(16'd0, 16'd0, 16'd0);
    test_random_traffic(60, 3);
    drain();
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF);
    test_random_traffic(60, 65535);
    drain();
    apply_settings(16'($urandom_range(1, 300)), 16'($urandom_range(1, 900)),
                   16'($urandom_range(1, 1200)));
    test_random_traffic(80, 400);
    drain();

    // catch any stray transfer after the last result
    repeat (10) @(negedge clk);
    if (fault_count == 0 && expected_leds.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
